// ===== hdl/indexed_pool_allocator_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the indexed pool allocator
// Shared wrappers that give every concurrent check the same clock, reset
// and report form.
// ----------------------------------------------------------------------------
`ifndef INDEXED_POOL_ALLOCATOR_TOP_DEFINES_SVH
`define INDEXED_POOL_ALLOCATOR_TOP_DEFINES_SVH

// General check on the rising clock edge, switched off while reset is high.
`define IPA_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A stalled item keeps its valid and its data until it is taken.
`define IPA_ASSERT_HOLD(label, clk, rst, vld, rdy, dat, msg) \
   label: assert property (@(posedge clk) disable iff (rst) \
      (vld && !rdy) |=> (vld && $stable(dat))) else $error(msg);

`endif

// ===== hdl/ipa_pkg.sv =====
// ----------------------------------------------------------------------------
// Indexed pool allocator package
// Sizes, command and status codes, link helpers and the types shared by
// the controller, the top level and the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ipa_pkg;

   // Pool size and derived address width.
   localparam int ENTRIES = 256;
   localparam int ADDR_W  = $clog2(ENTRIES);

   // Field widths.
   localparam int CMD_W    = 2;
   localparam int INDEX_W  = 9;
   localparam int STATUS_W = 2;
   localparam int HANDLE_W = 8;
   localparam int LINK_W   = 9;
   localparam int CNT_W    = 9;

   // Next-link memory word: used flag on top of the next link.
   localparam int NEXT_WORD_W = LINK_W + 1;

   // Stream data widths, padded to whole bytes.
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 48;

   // A link value that points nowhere.
   localparam logic [LINK_W-1:0] NO_LINK = '1;

   // Commands.
   localparam logic [CMD_W-1:0] CMD_CREATE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DESTROY = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NOP     = 2'd3;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE      = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_IN_USE = 2'd3;

   typedef logic [LINK_W-1:0] link_type;

   // Result item; the last member sits in the lowest bits.
   typedef struct packed {
      link_type              free_first;
      link_type              used_first;
      logic [CNT_W-1:0]      used_total;
      link_type              next_link;
      logic                  in_use;
      logic [HANDLE_W-1:0]   handle;
      logic [STATUS_W-1:0]   status;
   } rsp_type;

   localparam int RSP_W = $bits(rsp_type);

   // Request side of the next-link memory.
   typedef struct packed {
      logic                   rd_en;
      logic [ADDR_W-1:0]      rd_addr;
      logic                   wr_en;
      logic [ADDR_W-1:0]      wr_addr;
      logic [NEXT_WORD_W-1:0] wr_data;
   } next_port_type;

   // Request side of the prev-link memory.
   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      link_type          wr_data;
   } prev_port_type;

   // True when a link points at an entry of the pool.
   function automatic logic link_ok(input link_type v);
      return v < LINK_W'(ENTRIES);
   endfunction

endpackage

// ===== hdl/ipa_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/ipa_ctrl.sv =====
// ----------------------------------------------------------------------------
// Indexed pool allocator controller
// Formats the link memories after reset, then runs each command as a read
// of the link memories followed, for create and destroy, by link writes in ST_UPDATE, ST_LINK1 and ST_LINK2.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipa_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ipa_pkg::CMD_W-1:0]         req_command,
   input  logic [ipa_pkg::INDEX_W-1:0]       req_index,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output ipa_pkg::rsp_type                  rsp_data,
   output ipa_pkg::next_port_type            next_port,
   input  logic [ipa_pkg::NEXT_WORD_W-1:0]   next_rd_data,
   output ipa_pkg::prev_port_type            prev_port,
   input  ipa_pkg::link_type                 prev_rd_data
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE,
      ST_LINK1,
      ST_LINK2
   } state_type;

   state_type                         state_ff, state_in;
   logic [ipa_pkg::ADDR_W-1:0]        clear_cnt_ff, clear_cnt_in;
   ipa_pkg::link_type                 free_head_ff, free_head_in;
   ipa_pkg::link_type                 used_head_ff, used_head_in;
   logic [ipa_pkg::CNT_W-1:0]         used_count_ff, used_count_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   ipa_pkg::rsp_type                  rsp_ff, rsp_in;
   logic [ipa_pkg::CMD_W-1:0]         cmd_ff, cmd_in;
   logic [ipa_pkg::INDEX_W-1:0]       idx_ff, idx_in;

   // Link writes left over for the ST_LINK1 and ST_LINK2 states.
   logic                              fix_next_en_ff, fix_next_en_in;
   logic [ipa_pkg::ADDR_W-1:0]        fix_next_addr_ff, fix_next_addr_in;
   logic [ipa_pkg::NEXT_WORD_W-1:0]   fix_next_data_ff, fix_next_data_in;
   logic                              fix_prev1_en_ff, fix_prev1_en_in;
   logic [ipa_pkg::ADDR_W-1:0]        fix_prev1_addr_ff, fix_prev1_addr_in;
   ipa_pkg::link_type                 fix_prev1_data_ff, fix_prev1_data_in;
   logic                              fix_prev2_en_ff, fix_prev2_en_in;
   logic [ipa_pkg::ADDR_W-1:0]        fix_prev2_addr_ff, fix_prev2_addr_in;
   ipa_pkg::link_type                 fix_prev2_data_ff, fix_prev2_data_in;

   logic                              accept;
   logic                              out_free;
   logic                              clear_last;
   logic                              idx_ok;
   logic                              rd_flag;
   ipa_pkg::link_type                 rd_next;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign clear_last = (clear_cnt_ff == ipa_pkg::ADDR_W'(ipa_pkg::ENTRIES - 1));
   assign idx_ok     = (idx_ff < ipa_pkg::INDEX_W'(ipa_pkg::ENTRIES));
   assign rd_flag    = next_rd_data[ipa_pkg::LINK_W];
   assign rd_next    = next_rd_data[ipa_pkg::LINK_W-1:0];

   // Next-state logic for the sequencer and the memory requests.
   always_comb begin
      state_in          = state_ff;
      clear_cnt_in      = clear_cnt_ff;
      free_head_in      = free_head_ff;
      used_head_in      = used_head_ff;
      used_count_in     = used_count_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_tready;
      rsp_in            = rsp_ff;
      cmd_in            = cmd_ff;
      idx_in            = idx_ff;
      fix_next_en_in    = fix_next_en_ff;
      fix_next_addr_in  = fix_next_addr_ff;
      fix_next_data_in  = fix_next_data_ff;
      fix_prev1_en_in   = fix_prev1_en_ff;
      fix_prev1_addr_in = fix_prev1_addr_ff;
      fix_prev1_data_in = fix_prev1_data_ff;
      fix_prev2_en_in   = fix_prev2_en_ff;
      fix_prev2_addr_in = fix_prev2_addr_ff;
      fix_prev2_data_in = fix_prev2_data_ff;
      next_port         = '0;
      prev_port         = '0;

      // A create reads the free head; destroy and query read the index.
      next_port.rd_en   = accept;
      next_port.rd_addr = (req_command == ipa_pkg::CMD_CREATE) ?
                          free_head_ff[ipa_pkg::ADDR_W-1:0] :
                          req_index[ipa_pkg::ADDR_W-1:0];
      prev_port.rd_en   = accept;
      prev_port.rd_addr = req_index[ipa_pkg::ADDR_W-1:0];

      if (accept) begin
         cmd_in   = req_command;
         idx_in   = req_index;
         state_in = ST_UPDATE;
      end

      case (state_ff)
         ST_CLEAR: begin
            // Format the free list as 0..N-1 with end markers at both ends.
            next_port.wr_en   = 1'b1;
            next_port.wr_addr = clear_cnt_ff;
            next_port.wr_data = {1'b0, clear_last ? ipa_pkg::NO_LINK :
                                 ipa_pkg::LINK_W'(clear_cnt_ff) + ipa_pkg::LINK_W'(1)};
            prev_port.wr_en   = 1'b1;
            prev_port.wr_addr = clear_cnt_ff;
            prev_port.wr_data = (clear_cnt_ff == '0) ? ipa_pkg::NO_LINK :
                                ipa_pkg::LINK_W'(clear_cnt_ff) - ipa_pkg::LINK_W'(1);
            clear_cnt_in      = clear_cnt_ff + 1'b1;
            if (clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
         end
         ST_UPDATE: begin
            // Decide the command once the output register can take the result.
            if (out_free) begin
               rsp_in           = '0;
               rsp_in.status    = ipa_pkg::STATUS_OK;
               rsp_in.next_link = ipa_pkg::NO_LINK;
               state_in         = ST_IDLE;
               case (cmd_ff)
                  ipa_pkg::CMD_CREATE: begin
                     if (used_count_ff >= ipa_pkg::CNT_W'(ipa_pkg::ENTRIES) ||
                         !ipa_pkg::link_ok(free_head_ff)) begin
                        rsp_in.status = ipa_pkg::STATUS_FULL;
                     end else begin
                        // Pop the free head and push it onto the used list.
                        free_head_in      = rd_next;
                        used_head_in      = free_head_ff;
                        used_count_in     = used_count_ff + 1'b1;
                        next_port.wr_en   = 1'b1;
                        next_port.wr_addr = free_head_ff[ipa_pkg::ADDR_W-1:0];
                        next_port.wr_data = {1'b1, used_head_ff};
                        prev_port.wr_en   = 1'b1;
                        prev_port.wr_addr = free_head_ff[ipa_pkg::ADDR_W-1:0];
                        prev_port.wr_data = ipa_pkg::NO_LINK;
                        fix_next_en_in    = 1'b0;
                        fix_prev1_en_in   = ipa_pkg::link_ok(rd_next);
                        fix_prev1_addr_in = rd_next[ipa_pkg::ADDR_W-1:0];
                        fix_prev1_data_in = ipa_pkg::NO_LINK;
                        fix_prev2_en_in   = ipa_pkg::link_ok(used_head_ff);
                        fix_prev2_addr_in = used_head_ff[ipa_pkg::ADDR_W-1:0];
                        fix_prev2_data_in = free_head_ff;
                        rsp_in.handle     = free_head_ff[ipa_pkg::HANDLE_W-1:0];
                        rsp_in.in_use     = 1'b1;
                        rsp_in.next_link  = used_head_ff;
                        state_in          = ST_LINK1;
                     end
                  end
                  ipa_pkg::CMD_DESTROY: begin
                     if (!idx_ok) begin
                        rsp_in.status = ipa_pkg::STATUS_RANGE;
                     end else if (!rd_flag) begin
                        rsp_in.status = ipa_pkg::STATUS_NOT_IN_USE;
                     end else begin
                        // Unlink from the used list and push onto the free list.
                        if (idx_ff == used_head_ff) begin
                           used_head_in = rd_next;
                        end
                        free_head_in      = idx_ff;
                        used_count_in     = (used_count_ff != '0) ?
                                            used_count_ff - 1'b1 : used_count_ff;
                        next_port.wr_en   = 1'b1;
                        next_port.wr_addr = idx_ff[ipa_pkg::ADDR_W-1:0];
                        next_port.wr_data = {1'b0, free_head_ff};
                        prev_port.wr_en   = 1'b1;
                        prev_port.wr_addr = idx_ff[ipa_pkg::ADDR_W-1:0];
                        prev_port.wr_data = ipa_pkg::NO_LINK;
                        // The predecessor on the used list is itself in use.
                        fix_next_en_in    = ipa_pkg::link_ok(prev_rd_data);
                        fix_next_addr_in  = prev_rd_data[ipa_pkg::ADDR_W-1:0];
                        fix_next_data_in  = {1'b1, rd_next};
                        fix_prev1_en_in   = ipa_pkg::link_ok(rd_next);
                        fix_prev1_addr_in = rd_next[ipa_pkg::ADDR_W-1:0];
                        fix_prev1_data_in = prev_rd_data;
                        fix_prev2_en_in   = ipa_pkg::link_ok(free_head_ff);
                        fix_prev2_addr_in = free_head_ff[ipa_pkg::ADDR_W-1:0];
                        fix_prev2_data_in = idx_ff;
                        rsp_in.handle     = idx_ff[ipa_pkg::HANDLE_W-1:0];
                        rsp_in.next_link  = free_head_ff;
                        state_in          = ST_LINK1;
                     end
                  end
                  ipa_pkg::CMD_QUERY: begin
                     if (!idx_ok) begin
                        rsp_in.status = ipa_pkg::STATUS_RANGE;
                     end else begin
                        rsp_in.handle    = idx_ff[ipa_pkg::HANDLE_W-1:0];
                        rsp_in.in_use    = rd_flag;
                        rsp_in.next_link = rd_next;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_in.used_total = used_count_in;
               rsp_in.used_first = used_head_in;
               rsp_in.free_first = free_head_in;
               rsp_valid_in      = 1'b1;
            end
         end
         ST_LINK1: begin
            next_port.wr_en   = fix_next_en_ff;
            next_port.wr_addr = fix_next_addr_ff;
            next_port.wr_data = fix_next_data_ff;
            prev_port.wr_en   = fix_prev1_en_ff;
            prev_port.wr_addr = fix_prev1_addr_ff;
            prev_port.wr_data = fix_prev1_data_ff;
            state_in          = ST_LINK2;
         end
         ST_LINK2: begin
            prev_port.wr_en   = fix_prev2_en_ff;
            prev_port.wr_addr = fix_prev2_addr_ff;
            prev_port.wr_data = fix_prev2_data_ff;
            state_in          = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer state, format counter, list heads, used count and the result valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_cnt_ff  <= '0;
         free_head_ff  <= '0;
         used_head_ff  <= ipa_pkg::NO_LINK;
         used_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_cnt_ff  <= clear_cnt_in;
         free_head_ff  <= free_head_in;
         used_head_ff  <= used_head_in;
         used_count_ff <= used_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Item payload, result data and pending link writes.
   always_ff @(posedge clock) begin
      rsp_ff            <= rsp_in;
      cmd_ff            <= cmd_in;
      idx_ff            <= idx_in;
      fix_next_en_ff    <= fix_next_en_in;
      fix_next_addr_ff  <= fix_next_addr_in;
      fix_next_data_ff  <= fix_next_data_in;
      fix_prev1_en_ff   <= fix_prev1_en_in;
      fix_prev1_addr_ff <= fix_prev1_addr_in;
      fix_prev1_data_ff <= fix_prev1_data_in;
      fix_prev2_en_ff   <= fix_prev2_en_in;
      fix_prev2_addr_ff <= fix_prev2_addr_in;
      fix_prev2_data_ff <= fix_prev2_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ===== hdl/indexed_pool_allocator_top.sv =====
// ----------------------------------------------------------------------------
// Indexed pool allocator
// Hands out and takes back entry handles from a fixed pool, keeping free
// and used entries on two doubly linked lists in link memories.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one command item: create, destroy, query or
//   no operation, with an entry index. The rsp channel returns exactly one
//   result item per command: status, handle, used flag and next link of
//   the entry, plus the used count and both list heads after the command.
//   After reset the block formats its link memories, one entry a cycle;
//   req_tready stays low during that pass. Each command reads the link
//   memories when accepted; in ST_UPDATE its result is decided and
//   registered once the output register is free. Create and destroy
//   write links in ST_UPDATE, ST_LINK1 and ST_LINK2 on the single write
//   ports; query, no operation and rejected commands end in ST_UPDATE.
//   A result waits in the output register while rsp_tready is low; the
//   next command is still accepted and runs up to its result, which is
//   held back until the output register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module indexed_pool_allocator_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // Fields from bit 0: command[1:0], index[10:2], zero pad.
   input  logic [ipa_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // Fields from bit 0: status[1:0], handle[9:2], in_use[10], next_link[19:11],
   // used_total[28:20], used_first[37:29], free_first[46:38], zero pad.
   output logic [ipa_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   logic [ipa_pkg::CMD_W-1:0]       req_command;
   logic [ipa_pkg::INDEX_W-1:0]     req_index;
   ipa_pkg::rsp_type                rsp_data;
   ipa_pkg::next_port_type          next_port;
   logic [ipa_pkg::NEXT_WORD_W-1:0] next_rd_data;
   ipa_pkg::prev_port_type          prev_port;
   ipa_pkg::link_type               prev_rd_data;

   // Unpack the command item.
   assign req_command = req_tdata[ipa_pkg::CMD_W-1:0];
   assign req_index   = req_tdata[ipa_pkg::CMD_W +: ipa_pkg::INDEX_W];

   // Sequencer.
   ipa_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_command  (req_command),
      .req_index    (req_index),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_data     (rsp_data),
      .next_port    (next_port),
      .next_rd_data (next_rd_data),
      .prev_port    (prev_port),
      .prev_rd_data (prev_rd_data)
   );

   // Used flag and next link of every entry.
   ipa_ram #(
      .WIDTH (ipa_pkg::NEXT_WORD_W),
      .DEPTH (ipa_pkg::ENTRIES)
   ) u_next_ram (
      .clock   (clock),
      .wr_en   (next_port.wr_en),
      .wr_addr (next_port.wr_addr),
      .wr_data (next_port.wr_data),
      .rd_en   (next_port.rd_en),
      .rd_addr (next_port.rd_addr),
      .rd_data (next_rd_data)
   );

   // Previous link of every entry.
   ipa_ram #(
      .WIDTH (ipa_pkg::LINK_W),
      .DEPTH (ipa_pkg::ENTRIES)
   ) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_port.wr_en),
      .wr_addr (prev_port.wr_addr),
      .wr_data (prev_port.wr_data),
      .rd_en   (prev_port.rd_en),
      .rd_addr (prev_port.rd_addr),
      .rd_data (prev_rd_data)
   );

   // Pack the result item, zero padded to whole bytes.
   assign rsp_tdata = {{(ipa_pkg::RSP_DATA_W - ipa_pkg::RSP_W){1'b0}}, rsp_data};

endmodule

// ===== hdl/ipa_checker.sv =====
// ----------------------------------------------------------------------------
// Indexed pool allocator port checker
// Watches the top-level channels for handshake and result consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "indexed_pool_allocator_top_defines.svh"

module ipa_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [ipa_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [ipa_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   ipa_pkg::rsp_type rsp_view;
   logic             req_accept;
   logic             req_known;

   assign rsp_view   = rsp_tdata[ipa_pkg::RSP_W-1:0];
   assign req_accept = req_tvalid && req_tready;
   assign req_known  = (req_tdata != '0) || (req_tdata == '0);

   // A result waiting on the receiver must not change.
   `IPA_ASSERT_HOLD(a_rsp_hold, clock, reset, rsp_tvalid, rsp_tready, rsp_tdata, "rsp item changed while stalled")

   // Every accepted item takes the block out of idle, so req_tready drops.
   `IPA_ASSERT_CLK(a_busy_after_accept, clock, reset, (req_accept && req_known) |=> !req_tready, "req_tready high right after an accepted item")

   // Rejected commands carry a zero handle and flag and a next link of NO_LINK.
   `IPA_ASSERT_CLK(a_error_fields, clock, reset, (rsp_tvalid && rsp_view.status != ipa_pkg::STATUS_OK) |-> (rsp_view.handle == '0 && !rsp_view.in_use && rsp_view.next_link == ipa_pkg::NO_LINK), "error result with non-zero fields")

   // The used count never exceeds the pool.
   `IPA_ASSERT_CLK(a_count_bound, clock, reset, rsp_tvalid |-> (rsp_view.used_total <= ipa_pkg::CNT_W'(ipa_pkg::ENTRIES)), "used_total above pool size")

   // An entry reported in use implies a non-empty used list.
   `IPA_ASSERT_CLK(a_used_nonempty, clock, reset, (rsp_tvalid && rsp_view.status == ipa_pkg::STATUS_OK && rsp_view.in_use) |-> (rsp_view.used_total != '0 && rsp_view.used_first != ipa_pkg::NO_LINK), "entry in use while used list is empty")

endmodule

bind indexed_pool_allocator_top ipa_checker u_ipa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
